/* design/bts_pkg.sv */
// Shared types, constants and helper functions of the bilinear texture sampler.
// No dependencies; every other file of the block but bts_if imports this package.

package bts_pkg;

  // Field and datapath widths
  localparam int unsigned DimW     = 9;   // texture dimension register
  localparam int unsigned ChanW    = 8;   // one colour channel of a texel
  localparam int unsigned CoordW   = 18;  // signed Q2.16 coordinate
  localparam int unsigned UnitW    = 17;  // clamped coordinate, 0 .. 1.0
  localparam int unsigned FracW    = 16;  // fraction of a texel position
  localparam int unsigned PosW     = 24;  // Q8.16 texel position
  localparam int unsigned IdxW     = 16;  // linear texel address
  localparam int unsigned WeightW  = 33;  // bilinear weight, up to 2**32
  localparam int unsigned ProdW    = 41;  // weight times channel
  localparam int unsigned SumW     = 42;  // sum of four products
  localparam int unsigned OutW     = 16;  // Q8.8 result channel
  localparam int unsigned CornerN  = 4;
  localparam int unsigned ChanN    = 3;
  localparam int unsigned RegAddrW = 3;
  localparam int unsigned DataW    = 32;

  // Texel store sizing: linear addresses never exceed 16 bits
  localparam int unsigned MaxTexelsDef = 65536;
  localparam int unsigned StoreCap     = 65536;

  localparam logic [DimW-1:0]  DimReset = 9'd256;
  localparam logic [DimW-1:0]  DimMax   = 9'd256;
  localparam logic [UnitW-1:0] UnitOne  = 17'h10000;

  // Register codes, taken from paddr[2]
  localparam logic RegTexWidth  = 1'b0;
  localparam logic RegTexHeight = 1'b1;

  // Corner order: A (x0,y0), B (x1,y0), C (x1,y1), D (x0,y1)
  localparam int unsigned CrnA = 0;
  localparam int unsigned CrnB = 1;
  localparam int unsigned CrnC = 2;
  localparam int unsigned CrnD = 3;

  // Channel order inside the packed channel arrays
  localparam int unsigned ChBlue  = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChRed   = 2;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
  } dims_t;

  // Transaction leaving the coordinate stages
  typedef struct packed {
    logic                         func;
    logic [IdxW-1:0]              wr_index;
    rgb_t                         wr_texel;
    logic [CornerN-1:0][IdxW-1:0] addr;
    logic [FracW-1:0]             frac_s;
    logic [FracW-1:0]             frac_t;
  } corner_req_t;

  // Transaction leaving the texel store
  typedef struct packed {
    rgb_t [CornerN-1:0] corner;
    logic [FracW-1:0]   frac_s;
    logic [FracW-1:0]   frac_t;
  } corner_rsp_t;

  typedef struct packed {
    logic [OutW-1:0] red_out;
    logic [OutW-1:0] green_out;
    logic [OutW-1:0] blue_out;
  } result_t;

  // Zero reads as one, anything above 256 saturates
  function automatic logic [DimW-1:0] dim_of(input logic [DimW-1:0] r);
    logic [DimW-1:0] d;
    if (r == '0) begin
      d = 9'd1;
    end else if (r > DimMax) begin
      d = DimMax;
    end else begin
      d = r;
    end
    return d;
  endfunction

  // Clamp signed Q2.16 to 0 .. 1.0
  function automatic logic [UnitW-1:0] clamp_coord(input logic signed [CoordW-1:0] c);
    logic [UnitW-1:0] r;
    if (c[CoordW-1]) begin
      r = '0;
    end else if (c[UnitW-1:0] > UnitOne) begin
      r = UnitOne;
    end else begin
      r = c[UnitW-1:0];
    end
    return r;
  endfunction

endpackage

/* design/bts_if.sv */
// Valid/ready channel interfaces of the bilinear texture sampler.
// Input channel carries texel writes and sample requests; output carries results.

interface bts_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [15:0]        texel_index;
  logic [7:0]         texel_red;
  logic [7:0]         texel_green;
  logic [7:0]         texel_blue;
  logic signed [17:0] coord_u;
  logic signed [17:0] coord_v;

  modport source (
    output valid, func, texel_index, texel_red, texel_green, texel_blue, coord_u, coord_v,
    input  ready
  );
  modport sink (
    input  valid, func, texel_index, texel_red, texel_green, texel_blue, coord_u, coord_v,
    output ready
  );
endinterface

interface bts_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );
endinterface

/* design/bilinear_texture_sampler_top.sv */
// Top level of the bilinear texture sampler: registers, coordinate stages,
// texel store and blend. Depends on bts_pkg, bts_if and all bts_* modules.
//
// Usage:
//   in_i carries one transaction per valid/ready handshake: func 0 writes the
//   RGB texel at texel_index, func 1 samples at (coord_u, coord_v) in Q2.16.
//   out_o returns one Q8.8 RGB result per sample, in order; writes return none.
//   tex_width (byte address 0) and tex_height (byte address 4) are set over the
//   APB port while the block is idle; both reset to 256.
// Throughput: one transaction per cycle while out_o takes results, set by the seven register
//   stages (input, scale, address, store read, weights, products, output) each taking
//   one item per clock; the store has two copies, each read at two corners.
// Path: a sample passes the input, scale, address, store read, weights, products
//   and output registers in that order and is then presented on out_o.
// Stall: each stage moves while it is empty or its successor moves, so bubbles
//   close up and input keeps flowing until every stage holds an item.
// Reset: asynchronous, clears all stage valids and the registers; the texel
//   store is not cleared and must be written before it is sampled.

module bilinear_texture_sampler_top #(
  parameter int unsigned MAX_TEXELS = bts_pkg::MaxTexelsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bts_pkg::RegAddrW-1:0] paddr,
  input  logic [bts_pkg::DataW-1:0]    pwdata,
  output logic [bts_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  bts_in_if.sink                       in_i,
  bts_out_if.source                    out_o
);
  import bts_pkg::*;

  dims_t       dims;
  logic        req_valid, req_ready;
  corner_req_t req;
  logic        rsp_valid, rsp_ready;
  corner_rsp_t rsp;
  result_t     res;

  bts_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims_o  (dims)
  );

  bts_coord u_coord (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .in_if       (in_i),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  bts_texel_mem #(
    .MAX_TEXELS (MAX_TEXELS)
  ) u_texel_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  bts_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rsp_valid_i (rsp_valid),
    .rsp_ready_o (rsp_ready),
    .rsp_i       (rsp),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  // Drive the result channel payload
  assign out_o.red_out   = res.red_out;
  assign out_o.green_out = res.green_out;
  assign out_o.blue_out  = res.blue_out;

endmodule

/* design/bts_cfg_regs.sv */
// APB-style configuration registers: texture width and height.
// Depends on bts_pkg for register codes, widths and the dimension sanitiser.

module bts_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bts_pkg::RegAddrW-1:0]   paddr,
  input  logic [bts_pkg::DataW-1:0]      pwdata,
  output logic [bts_pkg::DataW-1:0]      prdata,
  output logic                           pready,
  output bts_pkg::dims_t                 dims_o
);
  import bts_pkg::*;

  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic            wr_en;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[RegAddrW-1];

  // Decode the write
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegTexWidth:  width_d  = pwdata[DimW-1:0];
        RegTexHeight: height_d = pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimReset;
      height_q <= DimReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Read back the raw register value
  always_comb begin
    unique case (reg_sel)
      RegTexWidth:  prdata = DataW'(width_q);
      RegTexHeight: prdata = DataW'(height_q);
      default:      prdata = '0;
    endcase
  end

  assign dims_o.w = dim_of(width_q);
  assign dims_o.h = dim_of(height_q);

endmodule

/* design/bts_coord.sv */
// Coordinate stages: clamp, scale to texel space, form the four corner addresses.
// Depends on bts_pkg and the bts_in_if channel interface.

module bts_coord (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bts_pkg::dims_t       dims_i,
  bts_in_if.sink               in_if,
  output logic                 req_valid_o,
  input  logic                 req_ready_i,
  output bts_pkg::corner_req_t req_o
);
  import bts_pkg::*;

  // Stage valids and advance enables
  logic s1_vld_q, s2_vld_q, s3_vld_q;
  logic s1_en, s2_en, s3_en;

  // Stage 1: registered transaction with clamped coordinates
  logic             func1_q;
  logic [IdxW-1:0]  idx1_q;
  rgb_t             tex1_q;
  logic [UnitW-1:0] u1_q, v1_q;

  // Stage 2: Q8.16 texel positions
  logic             func2_q;
  logic [IdxW-1:0]  idx2_q;
  rgb_t             tex2_q;
  logic [PosW-1:0]  px2_q, py2_q;

  // Stage 3 holds the outgoing transaction
  corner_req_t      req3_q, req3_d;

  logic [DimW-1:0]  wm1_full, hm1_full;
  logic [PosW:0]    px_full, py_full;
  logic [ChanW-1:0] x0, x1, y0, y1;
  logic [FracW-1:0] frac_s, frac_t;
  logic [UnitW-1:0] row0, row1;
  logic [UnitW-1:0] sum_a, sum_b, sum_c, sum_d;

  // Advance a stage when it is empty or its successor moves
  assign s3_en       = !s3_vld_q || req_ready_i;
  assign s2_en       = !s2_vld_q || s3_en;
  assign s1_en       = !s1_vld_q || s2_en;
  assign in_if.ready = s1_en;
  assign req_valid_o = s3_vld_q;
  assign req_o       = req3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (s1_en) s1_vld_q <= in_if.valid;
      if (s2_en) s2_vld_q <= s1_vld_q;
      if (s3_en) s3_vld_q <= s2_vld_q;
    end
  end

  // Stage 1: capture the transaction
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      func1_q      <= in_if.func;
      idx1_q       <= in_if.texel_index;
      tex1_q.red   <= in_if.texel_red;
      tex1_q.green <= in_if.texel_green;
      tex1_q.blue  <= in_if.texel_blue;
      u1_q         <= clamp_coord(in_if.coord_u);
      v1_q         <= clamp_coord(in_if.coord_v);
    end
  end

  // Stage 2: scale by dimension minus one
  assign wm1_full = dims_i.w - 9'd1;
  assign hm1_full = dims_i.h - 9'd1;
  assign px_full  = {8'b0, u1_q} * {17'b0, wm1_full[ChanW-1:0]};
  assign py_full  = {8'b0, v1_q} * {17'b0, hm1_full[ChanW-1:0]};

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      func2_q <= func1_q;
      idx2_q  <= idx1_q;
      tex2_q  <= tex1_q;
      px2_q   <= px_full[PosW-1:0];
      py2_q   <= py_full[PosW-1:0];
    end
  end

  // Stage 3: split position, step to the upper corner, form addresses
  assign x0     = px2_q[PosW-1:FracW];
  assign y0     = py2_q[PosW-1:FracW];
  assign frac_s = px2_q[FracW-1:0];
  assign frac_t = py2_q[FracW-1:0];
  assign x1     = x0 + {7'b0, |frac_s};
  assign y1     = y0 + {7'b0, |frac_t};
  assign row0   = {8'b0, dims_i.w} * {9'b0, y0};
  assign row1   = {8'b0, dims_i.w} * {9'b0, y1};
  assign sum_a  = row0 + {9'b0, x0};
  assign sum_b  = row0 + {9'b0, x1};
  assign sum_c  = row1 + {9'b0, x1};
  assign sum_d  = row1 + {9'b0, x0};

  always_comb begin
    req3_d.func       = func2_q;
    req3_d.wr_index   = idx2_q;
    req3_d.wr_texel   = tex2_q;
    req3_d.addr[CrnA] = sum_a[IdxW-1:0];
    req3_d.addr[CrnB] = sum_b[IdxW-1:0];
    req3_d.addr[CrnC] = sum_c[IdxW-1:0];
    req3_d.addr[CrnD] = sum_d[IdxW-1:0];
    req3_d.frac_s     = frac_s;
    req3_d.frac_t     = frac_t;
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) req3_q <= req3_d;
  end

endmodule

/* design/bts_texel_mem.sv */
// Texel store: two copies written together, each read at two corner addresses.
// Depends on bts_pkg for the transaction types and store sizing.

module bts_texel_mem #(
  parameter int unsigned MAX_TEXELS = bts_pkg::MaxTexelsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  bts_pkg::corner_req_t req_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output bts_pkg::corner_rsp_t rsp_o
);
  import bts_pkg::*;

  localparam int unsigned StoreDepth = (MAX_TEXELS > StoreCap) ? StoreCap : MAX_TEXELS;
  localparam int unsigned AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  rgb_t bank0_q [StoreDepth];
  rgb_t bank1_q [StoreDepth];

  logic                    vld_q;
  logic                    en;
  logic                    wr_en;
  logic                    rd_en;
  logic [AddrW-1:0]        wr_addr;
  logic [AddrW-1:0]        rd_addr [CornerN];
  logic [CornerN-1:0]      oor_d, oor_q;
  rgb_t [CornerN-1:0]      rd_q;
  logic [FracW-1:0]        frac_s_q, frac_t_q;

  assign en          = !vld_q || rsp_ready_i;
  assign req_ready_o = en;
  assign rsp_valid_o = vld_q;

  // Writes beyond the store are dropped; corners beyond it read as black
  assign wr_en   = en && req_valid_i && !req_i.func && (32'(req_i.wr_index) < StoreDepth);
  assign rd_en   = en && req_valid_i && req_i.func;
  assign wr_addr = req_i.wr_index[AddrW-1:0];

  always_comb begin
    for (int k = 0; k < CornerN; k++) begin
      rd_addr[k] = req_i.addr[k][AddrW-1:0];
      oor_d[k]   = 32'(req_i.addr[k]) >= StoreDepth;
    end
  end

  // Write both copies; copy 0 serves corners A and B, copy 1 corners C and D
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bank0_q[wr_addr] <= req_i.wr_texel;
      bank1_q[wr_addr] <= req_i.wr_texel;
    end
    if (rd_en) begin
      rd_q[CrnA] <= bank0_q[rd_addr[CrnA]];
      rd_q[CrnB] <= bank0_q[rd_addr[CrnB]];
      rd_q[CrnC] <= bank1_q[rd_addr[CrnC]];
      rd_q[CrnD] <= bank1_q[rd_addr[CrnD]];
    end
  end

  // Write transactions end here; only samples go on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= req_valid_i && req_i.func;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      oor_q    <= oor_d;
      frac_s_q <= req_i.frac_s;
      frac_t_q <= req_i.frac_t;
    end
  end

  always_comb begin
    for (int k = 0; k < CornerN; k++) begin
      rsp_o.corner[k] = oor_q[k] ? '0 : rd_q[k];
    end
    rsp_o.frac_s = frac_s_q;
    rsp_o.frac_t = frac_t_q;
  end

endmodule

/* design/bts_blend.sv */
// Bilinear blend: weights, per-channel products, then sum and Q8.8 truncation.
// Depends on bts_pkg for the transaction and result types.

module bts_blend (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rsp_valid_i,
  output logic                 rsp_ready_o,
  input  bts_pkg::corner_rsp_t rsp_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output bts_pkg::result_t     res_o
);
  import bts_pkg::*;

  function automatic logic [WeightW-1:0] mul_unit(input logic [UnitW-1:0] a,
                                                  input logic [UnitW-1:0] b);
    logic [2*UnitW-1:0] p;
    p = {17'b0, a} * {17'b0, b};
    return p[WeightW-1:0];
  endfunction

  logic e1_vld_q, e2_vld_q, e3_vld_q;
  logic e1_en, e2_en, e3_en;

  logic [UnitW-1:0]                         s_one, s_inv, t_one, t_inv;
  logic [CornerN-1:0][WeightW-1:0]          wgt_d, wgt1_q;
  rgb_t [CornerN-1:0]                       corner1_q;
  logic [CornerN-1:0][ChanN-1:0][ChanW-1:0] chan;
  logic [ChanN-1:0][CornerN-1:0][ProdW-1:0] prod_d, prod2_q;
  logic [ChanN-1:0][SumW-1:0]               sum;
  logic [ChanN-1:0][OutW-1:0]               out_q;

  assign e3_en       = !e3_vld_q || res_ready_i;
  assign e2_en       = !e2_vld_q || e3_en;
  assign e1_en       = !e1_vld_q || e2_en;
  assign rsp_ready_o = e1_en;
  assign res_valid_o = e3_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q <= 1'b0;
      e2_vld_q <= 1'b0;
      e3_vld_q <= 1'b0;
    end else begin
      if (e1_en) e1_vld_q <= rsp_valid_i;
      if (e2_en) e2_vld_q <= e1_vld_q;
      if (e3_en) e3_vld_q <= e2_vld_q;
    end
  end

  // Stage 1: 16-bit fractions to corner weights
  assign s_one = {1'b0, rsp_i.frac_s};
  assign t_one = {1'b0, rsp_i.frac_t};
  assign s_inv = UnitOne - s_one;
  assign t_inv = UnitOne - t_one;

  always_comb begin
    wgt_d[CrnA] = mul_unit(s_inv, t_inv);
    wgt_d[CrnB] = mul_unit(s_one, t_inv);
    wgt_d[CrnC] = mul_unit(s_one, t_one);
    wgt_d[CrnD] = mul_unit(s_inv, t_one);
  end

  always_ff @(posedge clk_i) begin
    if (e1_en) begin
      wgt1_q    <= wgt_d;
      corner1_q <= rsp_i.corner;
    end
  end

  // Stage 2: weight each channel of each corner
  always_comb begin
    for (int k = 0; k < CornerN; k++) begin
      chan[k][ChRed]   = corner1_q[k].red;
      chan[k][ChGreen] = corner1_q[k].green;
      chan[k][ChBlue]  = corner1_q[k].blue;
    end
    for (int c = 0; c < ChanN; c++) begin
      for (int k = 0; k < CornerN; k++) begin
        prod_d[c][k] = {8'b0, wgt1_q[k]} * {33'b0, chan[k][c]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e2_en) prod2_q <= prod_d;
  end

  // Stage 3: add the four corners and truncate to Q8.8
  always_comb begin
    for (int c = 0; c < ChanN; c++) begin
      sum[c] = {1'b0, prod2_q[c][CrnA]} + {1'b0, prod2_q[c][CrnB]}
             + {1'b0, prod2_q[c][CrnC]} + {1'b0, prod2_q[c][CrnD]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (e3_en) begin
      for (int c = 0; c < ChanN; c++) begin
        out_q[c] <= sum[c][OutW+2*ChanW+ChanW-1:2*ChanW+ChanW];
      end
    end
  end

  assign res_o.red_out   = out_q[ChRed];
  assign res_o.green_out = out_q[ChGreen];
  assign res_o.blue_out  = out_q[ChBlue];

endmodule

/* dv/bilinear_texture_sampler_top_test.sv */
// Self-checking testbench of the bilinear texture sampler: writes texels, samples
// them through the valid/ready channels and checks each filtered colour.
// Depends on bts_pkg, bts_if and the RTL under design/.

module bilinear_texture_sampler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bts_pkg::*;

  typedef enum logic {
    OpWrite  = 1'b0,
    OpSample = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [15:0]        index;
    rgb_t               texel;
    logic signed [17:0] u;
    logic signed [17:0] v;
  } texel_req_t;

  typedef struct packed {
    texel_req_t req;
    logic       check;
    result_t    want;
  } directed_row_t;

  localparam logic [17:0] CoordOne  = 18'h10000;
  localparam logic [17:0] CoordTop  = 18'h1FFFF;
  localparam logic [17:0] CoordLow  = 18'h20000;
  localparam int unsigned DrainWait = 12;
  localparam int unsigned IdlePct   = 37;
  localparam int unsigned PhaseN    = 11;
  localparam int unsigned PhaseLen  = 80;
  localparam logic [8:0]  SizeW [8] = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd2, 9'd17, 9'd3, 9'd256};
  localparam logic [8:0]  SizeH [8] = '{9'd0, 9'd256, 9'd1, 9'd300, 9'd2, 9'd9, 9'd5, 9'd256};

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [RegAddrW-1:0] paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  bts_in_if  in_ch ();
  bts_out_if out_ch ();

  bilinear_texture_sampler_top uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  // Shadow of the block: register copies, texel store and which entries hold data
  logic [8:0] width_reg;
  logic [8:0] height_reg;
  rgb_t       texels  [65536];
  bit         written [65536];

  result_t     filtered_due [$];
  int unsigned mismatches;
  int unsigned n_writes;
  int unsigned n_samples;
  int unsigned n_sizes;
  bit          calm;

  directed_row_t directed_rows [19];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d colours still due", filtered_due.size());
    $display("status: fail");
    $finish;
  end

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    if (mismatches < 30) begin
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  function automatic int unsigned eff_dim(input logic [8:0] r);
    if (r == 9'd0) return 1;
    if (r > 9'd256) return 256;
    return r;
  endfunction

  // Clamp a Q2.16 coordinate to 0..1 and scale it into a texel position
  function automatic void locate(input logic [17:0] c, input int unsigned dim,
                                 output int unsigned lo, output int unsigned hi,
                                 output int unsigned frac);
    int unsigned unit;
    int unsigned pos;
    if (c[17]) begin
      unit = 0;
    end else if (c[16:0] > 17'h10000) begin
      unit = 32'h10000;
    end else begin
      unit = c[16:0];
    end
    pos  = unit * (dim - 1);
    lo   = pos >> 16;
    frac = pos & 32'hFFFF;
    hi   = (frac != 0) ? lo + 1 : lo;
  endfunction

  function automatic void corner_addrs(input logic [17:0] u, input logic [17:0] v,
                                       output logic [3:0][15:0] addr,
                                       output int unsigned s, output int unsigned t);
    int unsigned x0, x1, y0, y1, w;
    w = eff_dim(width_reg);
    locate(u, w, x0, x1, s);
    locate(v, eff_dim(height_reg), y0, y1, t);
    addr[CrnA] = 16'(w * y0 + x0);
    addr[CrnB] = 16'(w * y0 + x1);
    addr[CrnC] = 16'(w * y1 + x1);
    addr[CrnD] = 16'(w * y1 + x0);
  endfunction

  // Weighted sum of the four corners per channel, truncated to Q8.8
  function automatic result_t blend_sample(input logic [17:0] u, input logic [17:0] v);
    logic [3:0][15:0] addr;
    int unsigned      s, t;
    longint unsigned  wt [4];
    longint unsigned  acc_r, acc_g, acc_b;
    result_t          r;
    corner_addrs(u, v, addr, s, t);
    wt[CrnA] = 64'(65536 - s) * 64'(65536 - t);
    wt[CrnB] = 64'(s) * 64'(65536 - t);
    wt[CrnC] = 64'(s) * 64'(t);
    wt[CrnD] = 64'(65536 - s) * 64'(t);
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    for (int k = 0; k < CornerN; k++) begin
      acc_r += wt[k] * texels[addr[k]].red;
      acc_g += wt[k] * texels[addr[k]].green;
      acc_b += wt[k] * texels[addr[k]].blue;
    end
    r.red_out   = acc_r[39:24];
    r.green_out = acc_g[39:24];
    r.blue_out  = acc_b[39:24];
    return r;
  endfunction

  function automatic texel_req_t random_req();
    texel_req_t r;
    r.op    = op_e'($urandom_range(1));
    r.index = 16'($urandom);
    r.texel = 24'($urandom);
    r.u     = 18'($urandom);
    r.v     = 18'($urandom);
    return r;
  endfunction

  // Mostly in range, with a share of exact edges, negatives and overshoots
  function automatic logic [17:0] rand_coord();
    logic [17:0] c;
    case ($urandom_range(9))
      0: c = 18'($urandom);
      1: c = '0;
      2: c = CoordOne;
      3: c = 18'($urandom_range(18'h3FFFF, CoordLow));
      4: c = 18'($urandom_range(CoordTop, CoordOne + 1));
      default: c = 18'($urandom_range(CoordOne, 0));
    endcase
    return c;
  endfunction

  function automatic directed_row_t wr_row(input logic [15:0] idx, input rgb_t texel);
    directed_row_t row;
    row           = '0;
    row.req.op    = OpWrite;
    row.req.index = idx;
    row.req.texel = texel;
    return row;
  endfunction

  function automatic directed_row_t smp_row(input logic [17:0] u, input logic [17:0] v,
                                            input logic check, input result_t want);
    directed_row_t row;
    row        = '0;
    row.req.op = OpSample;
    row.req.u  = u;
    row.req.v  = v;
    row.check  = check;
    row.want   = want;
    return row;
  endfunction

  // Offer one transaction after a random gap, then update the shadow on acceptance
  task automatic issue(input texel_req_t req, input logic typed, input result_t want);
    while (!calm && $urandom_range(99) < IdlePct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.func        <= req.op;
    in_ch.texel_index <= req.index;
    in_ch.texel_red   <= req.texel.red;
    in_ch.texel_green <= req.texel.green;
    in_ch.texel_blue  <= req.texel.blue;
    in_ch.coord_u     <= req.u;
    in_ch.coord_v     <= req.v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (req.op == OpWrite) begin
      texels[req.index]  = req.texel;
      written[req.index] = 1'b1;
      n_writes++;
    end else begin
      filtered_due.push_back(typed ? want : blend_sample(req.u, req.v));
      n_samples++;
    end
  endtask

  // Drop valid, drain every due colour and let in-flight writes land
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic code, input logic [DataW-1:0] wdata,
                          output logic [DataW-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {code, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_dims();
    logic [DataW-1:0] rd;
    apb_xfer(1'b0, RegTexWidth, '0, rd);
    if (rd !== {23'b0, width_reg}) flag("tex_width readback", {23'b0, width_reg}, rd);
    apb_xfer(1'b0, RegTexHeight, '0, rd);
    if (rd !== {23'b0, height_reg}) flag("tex_height readback", {23'b0, height_reg}, rd);
  endtask

  task automatic set_dims(input logic [8:0] w, input logic [8:0] h);
    logic [DataW-1:0] rd;
    settle();
    apb_xfer(1'b1, RegTexWidth, {23'b0, w}, rd);
    apb_xfer(1'b1, RegTexHeight, {23'b0, h}, rd);
    width_reg  = w;
    height_reg = h;
    check_dims();
    n_sizes++;
  endtask

  // Samples are preceded by writes of any corner not yet holding data
  task automatic run_random(input int unsigned quota, input bit pause_midway);
    int unsigned      done;
    texel_req_t       req;
    texel_req_t       wr;
    logic [3:0][15:0] addr;
    int unsigned      s, t;
    bit               paused;
    done   = 0;
    paused = 1'b0;
    while (done < quota) begin
      if (pause_midway && !paused && done >= quota / 2) begin
        settle();
        paused = 1'b1;
      end
      req = random_req();
      if ($urandom_range(99) < 20) begin
        req.op = OpWrite;
        issue(req, 1'b0, '0);
        done++;
      end else begin
        req.op = OpSample;
        req.u  = rand_coord();
        req.v  = rand_coord();
        corner_addrs(req.u, req.v, addr, s, t);
        for (int k = 0; k < CornerN; k++) begin
          if (!written[addr[k]]) begin
            wr       = random_req();
            wr.op    = OpWrite;
            wr.index = addr[k];
            issue(wr, 1'b0, '0);
            done++;
          end
        end
        issue(req, 1'b0, '0);
        done++;
      end
    end
  endtask

  // Receiver: stall at random except during a calm stretch
  initial begin
    forever begin
      @(negedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // Compare each accepted result with the oldest due colour
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (filtered_due.size() == 0) begin
          flag("result with nothing due", '0, {out_ch.red_out, out_ch.green_out});
        end else begin
          want = filtered_due.pop_front();
          if (out_ch.red_out !== want.red_out) flag("red_out", want.red_out, out_ch.red_out);
          if (out_ch.green_out !== want.green_out) begin
            flag("green_out", want.green_out, out_ch.green_out);
          end
          if (out_ch.blue_out !== want.blue_out) begin
            flag("blue_out", want.blue_out, out_ch.blue_out);
          end
        end
      end
    end
  end

  initial begin
    logic [8:0] w, h;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = OpWrite;
    in_ch.texel_index = '0;
    in_ch.texel_red   = '0;
    in_ch.texel_green = '0;
    in_ch.texel_blue  = '0;
    in_ch.coord_u     = '0;
    in_ch.coord_v     = '0;
    out_ch.ready      = 1'b0;
    calm              = 1'b0;
    width_reg         = DimReset;
    height_reg        = DimReset;
    mismatches        = 0;
    n_writes          = 0;
    n_samples         = 0;
    n_sizes           = 1;

    // Corners, clamping and mid-texel blends on the full 256 x 256 texture
    directed_rows = '{
      wr_row(16'd0, '{8'hFF, 8'h00, 8'h80}),
      smp_row(18'h0, 18'h0, 1'b1, '{16'hFF00, 16'h0000, 16'h8000}),
      smp_row(CoordLow, 18'h3FFFF, 1'b1, '{16'hFF00, 16'h0000, 16'h8000}),
      wr_row(16'd255, '{8'h00, 8'hFF, 8'h01}),
      smp_row(CoordOne, 18'h0, 1'b1, '{16'h0000, 16'hFF00, 16'h0100}),
      wr_row(16'd65280, '{8'h12, 8'h34, 8'h56}),
      smp_row(18'h0, CoordOne, 1'b1, '{16'h1200, 16'h3400, 16'h5600}),
      wr_row(16'd65535, '{8'hFF, 8'hFF, 8'hFF}),
      smp_row(CoordTop, CoordTop, 1'b1, '{16'hFF00, 16'hFF00, 16'hFF00}),
      smp_row(CoordOne, CoordOne + 1, 1'b1, '{16'hFF00, 16'hFF00, 16'hFF00}),
      wr_row(16'd127, '{8'h00, 8'h00, 8'h00}),
      wr_row(16'd128, '{8'hFF, 8'hFF, 8'hFF}),
      smp_row(18'h08000, 18'h0, 1'b0, '0),
      wr_row(16'd383, '{8'h40, 8'h80, 8'hC0}),
      wr_row(16'd384, '{8'h01, 8'h02, 8'h03}),
      smp_row(18'h08000, 18'h00101, 1'b0, '0),
      wr_row(16'hA5C3, '{8'h5A, 8'hA5, 8'h3C}),
      wr_row(16'd254, '{8'h80, 8'h80, 8'h80}),
      smp_row(18'h0FFFF, 18'h0, 1'b0, '0)
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_dims();
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].req, directed_rows[i].check, directed_rows[i].want);
    end

    // Walk the texture sizes: zero, one, saturating and random ones
    for (int p = 0; p < PhaseN; p++) begin
      if (p < 8) begin
        w = SizeW[p];
        h = SizeH[p];
      end else if (p < 10) begin
        w = 9'($urandom_range(32, 1));
        h = 9'($urandom_range(32, 1));
      end else begin
        w = 9'($urandom_range(511, 0));
        h = 9'($urandom_range(511, 0));
      end
      set_dims(w, h);
      calm = (p == 5);
      run_random(PhaseLen, p == 6);
    end
    calm = 1'b0;

    settle();
    $display("covered %0d texel writes and %0d filtered samples over %0d texture sizes",
             n_writes, n_samples, n_sizes);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
